### sv/clru_pkg.sv
// shared types and constants of the complex linear recurrence unit
// no dependencies; used by clru_cmac and complex_linear_recurrence_unit
package clru_pkg;

   localparam int DIM_W           = 10;
   localparam int DATA_W          = 32;
   localparam int REQ_TDATA_W     = 208;
   localparam int RSP_TDATA_W     = 80;
   localparam int MAX_DIMS_DEF    = 1024;
   localparam int FRAC_BITS_DEF   = 16;

   typedef struct packed {
      logic signed [DATA_W-1:0] im;
      logic signed [DATA_W-1:0] re;
   } cplx_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } ctl_state_type;

endpackage

### sv/clru_cmac.sv
// complex multiply-add h' = a*h + x with round to nearest and saturation
// depends on clru_pkg
module clru_cmac
   import clru_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  cplx_type decay,
   input  cplx_type prev,
   input  cplx_type impulse,
   output cplx_type result,
   output logic     saturated
);

   localparam int ACC_W = 2 * DATA_W + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W - 1){1'b0}}};

   logic signed [2*DATA_W-1:0] p_rr, p_ii, p_ri, p_ir;
   logic signed [ACC_W-1:0]    acc_re, acc_im;
   logic signed [ACC_W-1:0]    sum_re, sum_im;
   logic                       ovf_re, ovf_im;

   assign p_rr = decay.re * prev.re;
   assign p_ii = decay.im * prev.im;
   assign p_ri = decay.re * prev.im;
   assign p_ir = decay.im * prev.re;

   always_comb begin
      acc_re = ACC_W'(p_rr) - ACC_W'(p_ii) + HALF;
      acc_im = ACC_W'(p_ri) + ACC_W'(p_ir) + HALF;
      sum_re = (acc_re >>> FRAC_BITS) + ACC_W'(impulse.re);
      sum_im = (acc_im >>> FRAC_BITS) + ACC_W'(impulse.im);
      // out of range when the bits above the result sign disagree with it
      ovf_re = (sum_re[ACC_W-1:DATA_W-1] != {(ACC_W - DATA_W + 1){sum_re[ACC_W-1]}});
      ovf_im = (sum_im[ACC_W-1:DATA_W-1] != {(ACC_W - DATA_W + 1){sum_im[ACC_W-1]}});
      if (ovf_re) begin
         result.re = sum_re[ACC_W-1] ? NEG_LIM : POS_LIM;
      end else begin
         result.re = sum_re[DATA_W-1:0];
      end
      if (ovf_im) begin
         result.im = sum_im[ACC_W-1] ? NEG_LIM : POS_LIM;
      end else begin
         result.im = sum_im[DATA_W-1:0];
      end
      saturated = ovf_re | ovf_im;
   end

endmodule

### sv/complex_linear_recurrence_unit.sv
// complex linear recurrence unit: per-channel h = a*h + x in signed fixed point
// depends on clru_pkg and clru_cmac
//
// usage:
//   req channel: one transfer per step; tdata carries the channel, complex
//   decay, impulse and initial state, tuser flags the first step of a
//   sequence (the initial state then replaces the stored one).
//   rsp channel: one transfer per step with the channel, the new state and
//   in tuser a flag that a component was clamped.
//   rsp_tvalid rises once a request has passed the input stage and the result
//   register; one step is accepted every cycle while rsp_tready does not stall,
//   also back to back on the same channel, since the stored state is
//   forwarded around the state memory.
//   after reset the state memory is swept to zero, one entry per cycle, and
//   req_tready stays low until every entry is cleared.
//   when the receiver holds rsp_tready low the result register holds, one
//   more step waits in the input stage, then req_tready drops.
//   channels at or beyond MAX_DIMS store nothing and start from zero unless first_step.
module complex_linear_recurrence_unit
   import clru_pkg::*;
#(
   parameter int MAX_DIMS  = MAX_DIMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // dim_index, decay_re, decay_im, impulse_re, impulse_im, init_re, init_im, pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // first_step
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_dim_index, state_re, state_im, pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // saturated
   output logic                   rsp_tuser
);

   localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int EXT_W  = (ADDR_W > DIM_W) ? ADDR_W : DIM_W;
   localparam int RSP_PAD_W = RSP_TDATA_W - DIM_W - 2 * DATA_W;

   ctl_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clearing;

   logic [DIM_W-1:0]  req_dim_index;
   cplx_type          req_decay, req_impulse, req_init;
   logic [EXT_W-1:0]  req_idx_ext;
   logic              req_in_range;
   logic              req_xfer;

   logic              s1_valid_ff, s1_valid_in;
   logic [DIM_W-1:0]  s1_idx_ff;
   logic              s1_first_ff;
   logic              s1_store_ff;
   logic              s1_hit_ff;
   cplx_type          s1_decay_ff, s1_impulse_ff, s1_init_ff;
   cplx_type          s1_fwd_ff;
   logic [EXT_W-1:0]  s1_idx_ext;
   logic              s1_adv;
   cplx_type          s1_prev;
   cplx_type          s1_result;
   logic              s1_sat;

   cplx_type          state_mem [MAX_DIMS];
   cplx_type          rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   cplx_type          wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]  rsp_idx_ff;
   cplx_type          rsp_state_ff;
   logic              rsp_sat_ff;

   // request unpacking
   assign req_dim_index  = req_tdata[DIM_W-1:0];
   assign req_decay.re   = req_tdata[DIM_W+DATA_W-1:DIM_W];
   assign req_decay.im   = req_tdata[DIM_W+2*DATA_W-1:DIM_W+DATA_W];
   assign req_impulse.re = req_tdata[DIM_W+3*DATA_W-1:DIM_W+2*DATA_W];
   assign req_impulse.im = req_tdata[DIM_W+4*DATA_W-1:DIM_W+3*DATA_W];
   assign req_init.re    = req_tdata[DIM_W+5*DATA_W-1:DIM_W+4*DATA_W];
   assign req_init.im    = req_tdata[DIM_W+6*DATA_W-1:DIM_W+5*DATA_W];
   assign req_idx_ext    = EXT_W'(req_dim_index);
   assign req_in_range   = 32'(req_dim_index) < 32'(MAX_DIMS);
   assign s1_idx_ext     = EXT_W'(s1_idx_ff);

   // clear sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(MAX_DIMS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_RUN: begin
            clearing   = 1'b0;
            clr_cnt_in = clr_cnt_ff;
         end
         default: begin
            clearing   = 1'b1;
            clr_cnt_in = '0;
         end
      endcase
   end

   // handshake
   assign s1_adv      = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~clearing & (~s1_valid_ff | s1_adv);
   assign req_xfer    = req_tvalid & req_tready;
   assign s1_valid_in = req_xfer | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_tready);

   // previous state select with forwarding of the write in flight at read time
   always_comb begin
      if (s1_first_ff) begin
         s1_prev = s1_init_ff;
      end else if (!s1_store_ff) begin
         s1_prev = '0;
      end else if (s1_hit_ff) begin
         s1_prev = s1_fwd_ff;
      end else begin
         s1_prev = rd_data_ff;
      end
   end

   clru_cmac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cmac (
      .decay     (s1_decay_ff),
      .prev      (s1_prev),
      .impulse   (s1_impulse_ff),
      .result    (s1_result),
      .saturated (s1_sat)
   );

   // state memory write port
   always_comb begin
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_adv & s1_store_ff;
         wr_addr = s1_idx_ext[ADDR_W-1:0];
         wr_data = s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= state_mem[req_idx_ext[ADDR_W-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_idx_ff     <= req_dim_index;
         s1_first_ff   <= req_tuser;
         s1_store_ff   <= req_in_range;
         s1_decay_ff   <= req_decay;
         s1_impulse_ff <= req_impulse;
         s1_init_ff    <= req_init;
         s1_hit_ff     <= s1_adv & s1_store_ff & (s1_idx_ff == req_dim_index);
         s1_fwd_ff     <= s1_result;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_idx_ff   <= s1_idx_ff;
         rsp_state_ff <= s1_result;
         rsp_sat_ff   <= s1_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_state_ff.im, rsp_state_ff.re, rsp_idx_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule
